>>> rtl/efda_pkg.sv
package efda_pkg;

	localparam int unsigned ACC_WIDTH_DEF = 32;

	localparam logic [7:0]  SYNC_BYTE   = 8'hFF;
	localparam int unsigned PAYLOAD_LEN = 6;
	localparam int unsigned IDX_W       = 3;
	localparam logic [15:0] ENC_OFFSET  = 16'h8000;
	localparam int unsigned DELTA_W     = 15;

	// one frame's worth of decoded payload, valid when last is set
	typedef struct packed {
		logic        last;
		logic        ok;
		logic [15:0] enc_a;
		logic [15:0] enc_b;
		logic [15:0] pot;
	} frame_t;

endpackage

>>> rtl/efda_deframer.sv
module efda_deframer import efda_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic [7:0] rx_byte_s1,
	output frame_t     frame
);

	localparam logic [IDX_W-1:0] IDX_END = IDX_W'(PAYLOAD_LEN);

	logic             prev_sync_q;
	logic             in_frame_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       sum_q;
	logic [7:0]       store_q [PAYLOAD_LEN];

	logic sync_pair;
	logic is_sync;

	assign is_sync   = (rx_byte_s1 == SYNC_BYTE);
	assign sync_pair = is_sync && prev_sync_q;

	always_comb begin
		frame.last  = !sync_pair && in_frame_q && (idx_q == IDX_END);
		frame.ok    = (rx_byte_s1 == sum_q);
		frame.enc_a = {store_q[0], store_q[1]};
		frame.enc_b = {store_q[2], store_q[3]};
		frame.pot   = {store_q[4], store_q[5]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sync_q <= 1'b0;
			in_frame_q  <= 1'b0;
			idx_q       <= '0;
			sum_q       <= '0;
		end else if (adv) begin
			if (sync_pair) begin
				// sync pair restarts the frame, prev flag stays set
				in_frame_q <= 1'b1;
				idx_q      <= '0;
				sum_q      <= '0;
			end else begin
				prev_sync_q <= is_sync;
				if (in_frame_q) begin
					if (idx_q != IDX_END) begin
						idx_q <= idx_q + 1'b1;
						sum_q <= sum_q + rx_byte_s1;
					end else begin
						// checksum beat closes the frame
						prev_sync_q <= 1'b0;
						in_frame_q  <= 1'b0;
						idx_q       <= '0;
						sum_q       <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && !sync_pair && in_frame_q) begin
			for (int i = 0; i < PAYLOAD_LEN; i++) begin
				if (idx_q == IDX_W'(i))
					store_q[i] <= rx_byte_s1;
			end
		end
	end

endmodule

>>> rtl/efda_enc_acc.sv
module efda_enc_acc import efda_pkg::*; #(
	parameter int unsigned ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 upd,
	input  logic                 first,
	input  logic [15:0]          word,
	output logic [ACC_WIDTH-1:0] total_nxt
);

	logic [15:0]          ref_q;
	logic [ACC_WIDTH-1:0] total_q;

	logic [15:0]          enc;
	logic [15:0]          ref_sel;
	logic [15:0]          diff;
	logic [ACC_WIDTH-1:0] inc;
	logic [ACC_WIDTH-1:0] total_sum;

	always_comb begin
		enc       = ENC_OFFSET - word;
		ref_sel   = first ? enc : ref_q;
		diff      = enc - ref_sel;
		// delta mod 2^15 taken as signed gives -16384..16383
		inc       = ACC_WIDTH'(signed'(diff[DELTA_W-1:0]));
		total_sum = total_q + inc;
		total_nxt = upd ? total_sum : total_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q   <= '0;
			total_q <= '0;
		end else if (upd) begin
			ref_q   <= enc;
			total_q <= total_sum;
		end
	end

endmodule

>>> rtl/encoder_frame_deframer_accumulator_core.sv
// Serial frame deframer with two encoder tick accumulators. One byte beat
// is taken per cycle unless the output stalls; a byte enters an input
// register and the whole frame/checksum/accumulate update runs in the
// single stage after it, loading the output registers on a checksum byte.
// Two 0xFF bytes in a row (re)start a frame of six payload bytes
// and a mod-256 checksum; only the checksum byte yields a result beat.
// Encoder words carry 32768 minus the count; deltas are taken mod 32768 as
// signed and summed into ACC_WIDTH-bit wrapping totals, reported as the
// low 32 bits of their sign extension. The first good frame sets the
// references only. A bad frame reports the unchanged totals and pot word.
module encoder_frame_deframer_accumulator_core import efda_pkg::*; #(
	parameter int unsigned ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               checksum_ok,
	output logic signed [31:0] left_ticks,
	output logic signed [31:0] right_ticks,
	output logic [15:0]        pot_value
);

	logic        valid_s1;
	logic [7:0]  rx_byte_s1;
	logic        first_q;
	logic [15:0] pot_q;

	logic               out_valid_q;
	logic               ok_q;
	logic signed [31:0] left_q;
	logic signed [31:0] right_q;
	logic [15:0]        pot_out_q;

	logic                 fire;
	logic                 upd;
	frame_t               frame;
	logic [ACC_WIDTH-1:0] left_nxt;
	logic [ACC_WIDTH-1:0] right_nxt;
	logic signed [63:0]   left_ext;
	logic signed [63:0]   right_ext;

	assign fire     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire;
	assign upd      = fire && frame.last && frame.ok;

	assign left_ext  = 64'(signed'(left_nxt));
	assign right_ext = 64'(signed'(right_nxt));

	efda_deframer u_deframer (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (fire),
		.rx_byte_s1 (rx_byte_s1),
		.frame      (frame)
	);

	efda_enc_acc #(.ACC_WIDTH(ACC_WIDTH)) u_acc_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (upd),
		.first     (first_q),
		.word      (frame.enc_a),
		.total_nxt (left_nxt)
	);

	efda_enc_acc #(.ACC_WIDTH(ACC_WIDTH)) u_acc_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (upd),
		.first     (first_q),
		.word      (frame.enc_b),
		.total_nxt (right_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			first_q     <= 1'b1;
			pot_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (upd) begin
				first_q <= 1'b0;
				pot_q   <= frame.pot;
			end
			if (fire)
				out_valid_q <= frame.last;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall)
			rx_byte_s1 <= rx_byte;
		if (fire && frame.last) begin
			ok_q      <= frame.ok;
			left_q    <= left_ext[31:0];
			right_q   <= right_ext[31:0];
			pot_out_q <= frame.ok ? frame.pot : pot_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign checksum_ok = ok_q;
	assign left_ticks  = left_q;
	assign right_ticks = right_q;
	assign pot_value   = pot_out_q;

endmodule
